// ----- design/timed_button_press_injector_top_macros.svh -----
// Assertion macros shared by the button-press injector RTL.
// Depends on the asserting module having signals named clk and rst_n.
`ifndef TIMED_BUTTON_PRESS_INJECTOR_TOP_MACROS_SVH
`define TIMED_BUTTON_PRESS_INJECTOR_TOP_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TBPI_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("Same-cycle check failed.");

// The consequent must hold in the cycle after the antecedent.
`define TBPI_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("Next-cycle check failed.");

`endif

// ----- design/tbpi_pkg.sv -----
// Package for the button-press injector: sizes, command codes, phase type
// and the payload and control structs. No dependencies.
package tbpi_pkg;

  localparam int QUEUE_DEPTH  = 8;
  localparam int BUTTON_COUNT = 8;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  localparam logic [PTR_W:0]   DEPTH_SUM  = (PTR_W + 1)'(QUEUE_DEPTH);
  localparam logic [PTR_W-1:0] LAST_PTR   = PTR_W'(QUEUE_DEPTH - 1);
  localparam logic [CNT_W-1:0] COUNT_FULL = CNT_W'(QUEUE_DEPTH);
  localparam logic [3:0]       BUTTON_LIMIT = 4'(BUTTON_COUNT);
  localparam logic [31:0]      FRAME_NONE = 32'hFFFF_FFFF;

  localparam logic [1:0] CMD_ENQUEUE = 2'd0;
  localparam logic [1:0] CMD_FRAME   = 2'd1;
  localparam logic [1:0] CMD_CLEAR   = 2'd2;

  typedef enum logic [2:0] {
    PH_IDLE     = 3'b001,
    PH_DOWN     = 3'b010,
    PH_RELEASED = 3'b100
  } phase_t;

  typedef struct packed {
    logic [1:0]  command;
    logic [3:0]  button;
    logic [31:0] hold_time;
    logic [31:0] frame_number;
    logic [31:0] now_time;
  } in_item_t;

  typedef struct packed {
    logic        accepted;
    logic        pressed_edge;
    logic        released_edge;
    logic        is_down;
    logic        is_active;
    logic        held_valid;
    logic [3:0]  held_button;
    logic [31:0] held_time;
    logic [3:0]  pending_count;
  } out_item_t;

  typedef struct packed {
    logic        push;
    logic        pop;
    logic        clear;
    logic [3:0]  wr_button;
    logic [31:0] wr_hold;
  } fifo_ctrl_t;

  typedef struct packed {
    logic [CNT_W-1:0] count;
    logic [3:0]       rd_button;
    logic [31:0]      rd_hold;
  } fifo_stat_t;

endpackage

// ----- design/tbpi_fifo.sv -----
// Press queue: circular buffer of (button, hold time) entries with head and count.
// Depends on tbpi_pkg.
module tbpi_fifo import tbpi_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  fifo_ctrl_t ctrl,
  output fifo_stat_t stat
);

  logic [3:0]       button_mem [QUEUE_DEPTH];
  logic [31:0]      hold_mem   [QUEUE_DEPTH];
  logic [PTR_W-1:0] head_r, head_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [PTR_W:0]   tail_sum;
  logic [PTR_W-1:0] tail;
  logic [3:0]       rd_button_r;
  logic [31:0]      rd_hold_r;

  always_comb begin
    tail_sum = {1'b0, head_r} + (PTR_W + 1)'(count_r);
    if (tail_sum >= DEPTH_SUM) begin
      tail = PTR_W'(tail_sum - DEPTH_SUM);
    end else begin
      tail = tail_sum[PTR_W-1:0];
    end
  end

  always_comb begin
    head_nxt  = head_r;
    count_nxt = count_r;
    if (ctrl.clear) begin
      head_nxt  = '0;
      count_nxt = '0;
    end else if (ctrl.push) begin
      count_nxt = count_r + 1'b1;
    end else if (ctrl.pop) begin
      head_nxt  = (head_r == LAST_PTR) ? '0 : head_r + 1'b1;
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      count_r <= '0;
    end else begin
      head_r  <= head_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.push && !ctrl.clear) begin
      button_mem[tail] <= ctrl.wr_button;
      hold_mem[tail]   <= ctrl.wr_hold;
    end
  end

  // The head entry is registered from the next head pointer; a push into an empty queue is forwarded.
  always_ff @(posedge clk) begin
    if (ctrl.push && !ctrl.clear && tail == head_nxt) begin
      rd_button_r <= ctrl.wr_button;
      rd_hold_r   <= ctrl.wr_hold;
    end else begin
      rd_button_r <= button_mem[head_nxt];
      rd_hold_r   <= hold_mem[head_nxt];
    end
  end

  assign stat.count     = count_r;
  assign stat.rd_button = rd_button_r;
  assign stat.rd_hold   = rd_hold_r;

endmodule

// ----- design/timed_button_press_injector_top.sv -----
// A command taken on start is registered in in_r; its result is registered in out_r and shown on out_valid.
// Throughput: one command per cycle; busy is always low.
// Each command gives exactly one result strobe; the receiver cannot stall.
// Synchronous active-low reset returns to Idle with an empty queue.
// Depends on tbpi_pkg, tbpi_fifo and timed_button_press_injector_top_macros.svh.
`include "timed_button_press_injector_top_macros.svh"

module timed_button_press_injector_top import tbpi_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  in_item_t  in_data,
  output logic      out_valid,
  output out_item_t out_data
);

  logic       in_valid_r;
  in_item_t   in_r;
  logic       out_valid_r;
  out_item_t  out_r;

  phase_t      phase_r, phase_nxt;
  logic        cur_valid_r, cur_valid_nxt;
  logic [3:0]  cur_button_r, cur_button_nxt;
  logic        press_edge_r, press_edge_nxt;
  logic        release_edge_r, release_edge_nxt;
  logic [31:0] press_start_r, press_start_nxt;
  logic [31:0] hold_target_r, hold_target_nxt;
  logic [31:0] elapsed_r, elapsed_nxt;
  logic [31:0] last_frame_r, last_frame_nxt;

  logic             acc;
  logic [31:0]      diff;
  logic [CNT_W-1:0] pending_nxt;
  fifo_ctrl_t       fctrl;
  fifo_stat_t       fstat;

  assign busy = 1'b0;

  tbpi_fifo u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .ctrl  (fctrl),
    .stat  (fstat)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else begin
      in_valid_r <= start;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      in_r <= in_data;
    end
  end

  assign diff = in_r.now_time - press_start_r;

  always_comb begin
    phase_nxt        = phase_r;
    cur_valid_nxt    = cur_valid_r;
    cur_button_nxt   = cur_button_r;
    press_edge_nxt   = press_edge_r;
    release_edge_nxt = release_edge_r;
    press_start_nxt  = press_start_r;
    hold_target_nxt  = hold_target_r;
    elapsed_nxt      = elapsed_r;
    last_frame_nxt   = last_frame_r;
    acc              = 1'b0;
    fctrl.push       = 1'b0;
    fctrl.pop        = 1'b0;
    fctrl.clear      = 1'b0;
    fctrl.wr_button  = in_r.button;
    fctrl.wr_hold    = in_r.hold_time;
    if (in_valid_r) begin
      case (in_r.command)
        CMD_ENQUEUE: begin
          if (in_r.button < BUTTON_LIMIT && fstat.count != COUNT_FULL) begin
            fctrl.push = 1'b1;
            acc        = 1'b1;
          end
        end
        CMD_FRAME: begin
          if (in_r.frame_number != last_frame_r) begin
            acc              = 1'b1;
            last_frame_nxt   = in_r.frame_number;
            press_edge_nxt   = 1'b0;
            release_edge_nxt = 1'b0;
            case (phase_r)
              PH_RELEASED: begin
                phase_nxt      = PH_IDLE;
                cur_valid_nxt  = 1'b0;
                cur_button_nxt = '0;
                elapsed_nxt    = '0;
              end
              PH_DOWN: begin
                elapsed_nxt = diff;
                if (diff >= hold_target_r) begin
                  release_edge_nxt = 1'b1;
                  phase_nxt        = PH_RELEASED;
                end
              end
              PH_IDLE: begin
                if (fstat.count != '0) begin
                  fctrl.pop       = 1'b1;
                  cur_valid_nxt   = 1'b1;
                  cur_button_nxt  = fstat.rd_button;
                  hold_target_nxt = fstat.rd_hold;
                  press_start_nxt = in_r.now_time;
                  elapsed_nxt     = '0;
                  press_edge_nxt  = 1'b1;
                  phase_nxt       = PH_DOWN;
                end
              end
              default: begin
                phase_nxt = PH_IDLE;
              end
            endcase
          end
        end
        CMD_CLEAR: begin
          acc              = 1'b1;
          fctrl.clear      = 1'b1;
          phase_nxt        = PH_IDLE;
          cur_valid_nxt    = 1'b0;
          cur_button_nxt   = '0;
          press_edge_nxt   = 1'b0;
          release_edge_nxt = 1'b0;
          press_start_nxt  = '0;
          hold_target_nxt  = '0;
          elapsed_nxt      = '0;
          last_frame_nxt   = FRAME_NONE;
        end
        default: begin
          acc = 1'b0;
        end
      endcase
    end
  end

  always_comb begin
    if (fctrl.clear) begin
      pending_nxt = '0;
    end else if (fctrl.push) begin
      pending_nxt = fstat.count + 1'b1;
    end else if (fctrl.pop) begin
      pending_nxt = fstat.count - 1'b1;
    end else begin
      pending_nxt = fstat.count;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r        <= PH_IDLE;
      cur_valid_r    <= 1'b0;
      cur_button_r   <= '0;
      press_edge_r   <= 1'b0;
      release_edge_r <= 1'b0;
      press_start_r  <= '0;
      hold_target_r  <= '0;
      elapsed_r      <= '0;
      last_frame_r   <= FRAME_NONE;
      out_valid_r    <= 1'b0;
    end else begin
      phase_r        <= phase_nxt;
      cur_valid_r    <= cur_valid_nxt;
      cur_button_r   <= cur_button_nxt;
      press_edge_r   <= press_edge_nxt;
      release_edge_r <= release_edge_nxt;
      press_start_r  <= press_start_nxt;
      hold_target_r  <= hold_target_nxt;
      elapsed_r      <= elapsed_nxt;
      last_frame_r   <= last_frame_nxt;
      out_valid_r    <= in_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid_r) begin
      out_r.accepted      <= acc;
      out_r.pressed_edge  <= press_edge_nxt;
      out_r.released_edge <= release_edge_nxt;
      out_r.is_down       <= (phase_nxt == PH_DOWN);
      out_r.is_active     <= (phase_nxt == PH_DOWN) || release_edge_nxt;
      out_r.held_valid    <= cur_valid_nxt;
      out_r.held_button   <= cur_valid_nxt ? cur_button_nxt : 4'd0;
      out_r.held_time     <= elapsed_nxt;
      out_r.pending_count <= 4'(pending_nxt);
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  `TBPI_ASSERT_NEXT(a_result_follows_item, in_valid_r, out_valid_r)
  `TBPI_ASSERT_NOW(a_press_means_down, out_valid_r && out_r.pressed_edge,
                   out_r.is_down && out_r.held_valid)
  `TBPI_ASSERT_NOW(a_release_not_down, out_valid_r && out_r.released_edge, !out_r.is_down)
  `TBPI_ASSERT_NOW(a_down_has_button, phase_r == PH_DOWN, cur_valid_r)
  `TBPI_ASSERT_NOW(a_count_bounded, 1'b1, fstat.count <= COUNT_FULL)

endmodule

// ----- tb/tb.sv -----
// Self-checking testbench for timed_button_press_injector_top: a directed pass,
// then randomized press, frame and clear traffic checked against a scoreboard.
// Depends on tbpi_pkg and the injector RTL.
module tb;
  import tbpi_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int RANDOM_STAGES = 4;
  localparam int STAGE_ITEMS = 260;

  class press_scoreboard;
    logic [3:0]  slot_button [QUEUE_DEPTH];
    logic [31:0] slot_hold [QUEUE_DEPTH];
    int unsigned head;
    int unsigned count;
    phase_t      ph;
    logic        cur_valid;
    logic [3:0]  cur_button;
    logic        pressed;
    logic        released;
    logic [31:0] down_since;
    logic [31:0] hold_goal;
    logic [31:0] held_ms;
    logic [31:0] last_seq;
    out_item_t   expected_reports [$];
    int          failures;

    function new();
      failures = 0;
      clear_state();
    endfunction

    function void clear_state();
      head = 0;
      count = 0;
      ph = PH_IDLE;
      cur_valid = 1'b0;
      cur_button = '0;
      pressed = 1'b0;
      released = 1'b0;
      down_since = '0;
      hold_goal = '0;
      held_ms = '0;
      last_seq = FRAME_NONE;
    endfunction

    function string show(out_item_t r);
      return $sformatf("acc=%b pe=%b re=%b dn=%b act=%b hv=%b hb=%h ht=%h pc=%0d",
                       r.accepted, r.pressed_edge, r.released_edge, r.is_down,
                       r.is_active, r.held_valid, r.held_button, r.held_time,
                       r.pending_count);
    endfunction

    function void note_command(in_item_t c);
      out_item_t   r;
      logic        took;
      int unsigned slot;
      took = 1'b0;
      case (c.command)
        CMD_ENQUEUE: begin
          if (c.button < BUTTON_COUNT && count < QUEUE_DEPTH) begin
            slot = (head + count) % QUEUE_DEPTH;
            slot_button[slot] = c.button;
            slot_hold[slot] = c.hold_time;
            count++;
            took = 1'b1;
          end
        end
        CMD_FRAME: begin
          if (c.frame_number != last_seq) begin
            took = 1'b1;
            last_seq = c.frame_number;
            pressed = 1'b0;
            released = 1'b0;
            case (ph)
              PH_RELEASED: begin
                ph = PH_IDLE;
                cur_valid = 1'b0;
                cur_button = '0;
                held_ms = '0;
              end
              PH_DOWN: begin
                held_ms = c.now_time - down_since;
                if (held_ms >= hold_goal) begin
                  released = 1'b1;
                  ph = PH_RELEASED;
                end
              end
              default: begin
                if (count != 0) begin
                  slot = head;
                  head = (head + 1) % QUEUE_DEPTH;
                  count--;
                  cur_valid = 1'b1;
                  cur_button = slot_button[slot];
                  hold_goal = slot_hold[slot];
                  down_since = c.now_time;
                  held_ms = '0;
                  pressed = 1'b1;
                  ph = PH_DOWN;
                end
              end
            endcase
          end
        end
        CMD_CLEAR: begin
          clear_state();
          took = 1'b1;
        end
        default: ;
      endcase
      r.accepted = took;
      r.pressed_edge = pressed;
      r.released_edge = released;
      r.is_down = (ph == PH_DOWN);
      r.is_active = (ph == PH_DOWN) || released;
      r.held_valid = cur_valid;
      r.held_button = cur_valid ? cur_button : 4'd0;
      r.held_time = held_ms;
      r.pending_count = 4'(count);
      expected_reports.push_back(r);
    endfunction

    function void check_report(out_item_t got);
      out_item_t want;
      logic      bad;
      if (expected_reports.size() == 0) begin
        failures++;
        if (failures <= 10)
          $display("Unexpected result transfer: %s", show(got));
        return;
      end
      want = expected_reports.pop_front();
      bad = (got.accepted !== want.accepted) || (got.pressed_edge !== want.pressed_edge) ||
            (got.released_edge !== want.released_edge) || (got.is_down !== want.is_down) ||
            (got.is_active !== want.is_active) || (got.held_valid !== want.held_valid) ||
            (got.held_button !== want.held_button) || (got.held_time !== want.held_time) ||
            (got.pending_count !== want.pending_count);
      if (bad) begin
        failures++;
        if (failures <= 10)
          $display("Mismatch at %0t: expected %s, got %s", $realtime, show(want), show(got));
      end
    endfunction
  endclass

  logic      clk;
  logic      rst_n;
  logic      start;
  logic      busy;
  in_item_t  in_data;
  logic      out_valid;
  out_item_t out_data;

  press_scoreboard sb;
  bit              gaps_enabled;
  int              quiet_cycles;
  logic [31:0]     seq_counter;
  logic [31:0]     clock_ms;

  timed_button_press_injector_top dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_data (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin : monitor
    bit progress;
    progress = 1'b0;
    if (!rst_n) begin
      quiet_cycles = 0;
    end else begin
      if (start && !busy) begin
        sb.note_command(in_data);
        progress = 1'b1;
      end
      if (out_valid === 1'b1) begin
        sb.check_report(out_data);
        progress = 1'b1;
      end
      quiet_cycles = progress ? 0 : quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  function automatic in_item_t command_item(logic [1:0] cmd, logic [3:0] button,
                                            logic [31:0] hold, logic [31:0] seq,
                                            logic [31:0] now);
    in_item_t it;
    it.command = cmd;
    it.button = button;
    it.hold_time = hold;
    it.frame_number = seq;
    it.now_time = now;
    return it;
  endfunction

  function automatic in_item_t random_command();
    in_item_t it;
    int       pick;
    it.button = 4'($urandom);
    it.hold_time = $urandom;
    it.frame_number = $urandom;
    it.now_time = $urandom;
    pick = $urandom_range(99);
    if (pick < 36) begin
      it.command = CMD_ENQUEUE;
      if ($urandom_range(9) != 0)
        it.button = 4'($urandom_range(BUTTON_COUNT - 1));
      if ($urandom_range(19) != 0)
        it.hold_time = $urandom_range(60);
    end else if (pick < 92) begin
      it.command = CMD_FRAME;
      if ($urandom_range(15) != 0)
        seq_counter = seq_counter + (($urandom_range(29) == 0) ? $urandom : 32'd1);
      it.frame_number = seq_counter;
      clock_ms = clock_ms + (($urandom_range(49) == 0) ? $urandom : $urandom_range(25));
      it.now_time = clock_ms;
    end else if (pick < 96) begin
      it.command = CMD_CLEAR;
    end else begin
      it.command = CMD_UNUSED;
    end
    return it;
  endfunction

  task automatic send_command(in_item_t item);
    while (gaps_enabled && $urandom_range(99) < 37) begin
      @(negedge clk);
      start <= 1'b0;
      in_data <= random_command();
    end
    @(negedge clk);
    start <= 1'b1;
    in_data <= item;
    do @(posedge clk); while (busy);
  endtask

  task automatic wait_for_results();
    @(negedge clk);
    start <= 1'b0;
    while (sb.expected_reports.size() != 0) @(negedge clk);
  endtask

  initial begin
    sb = new();
    rst_n = 1'b0;
    start = 1'b0;
    in_data = '0;
    gaps_enabled = 1'b1;
    seq_counter = $urandom;
    clock_ms = $urandom;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    send_command(command_item(CMD_FRAME, 4'd0, 32'd0, FRAME_NONE, 32'd50));
    send_command(command_item(CMD_FRAME, 4'd0, 32'd0, 32'd0, 32'd100));
    send_command(command_item(CMD_ENQUEUE, 4'd15, 32'd5, 32'd0, 32'd0));
    send_command(command_item(CMD_ENQUEUE, 4'(BUTTON_COUNT), 32'd5, 32'd0, 32'd0));
    send_command(command_item(CMD_ENQUEUE, 4'd0, 32'd0, 32'd0, 32'd0));
    send_command(command_item(CMD_ENQUEUE, 4'(BUTTON_COUNT - 1), 32'hFFFF_FFFF,
                              32'd0, 32'd0));
    send_command(command_item(CMD_UNUSED, 4'd3, 32'd9, 32'd7, 32'd7));
    send_command(command_item(CMD_FRAME, 4'd0, 32'd0, 32'd1, 32'd200));
    send_command(command_item(CMD_FRAME, 4'd0, 32'd0, 32'd1, 32'd900));
    send_command(command_item(CMD_FRAME, 4'd0, 32'd0, 32'd2, 32'd200));
    send_command(command_item(CMD_FRAME, 4'd0, 32'd0, 32'd3, 32'd210));
    send_command(command_item(CMD_FRAME, 4'd0, 32'd0, 32'd4, 32'hFFFF_FFF0));
    send_command(command_item(CMD_FRAME, 4'd0, 32'd0, 32'd5, 32'h0000_0010));
    for (int i = 0; i <= QUEUE_DEPTH; i++)
      send_command(command_item(CMD_ENQUEUE, 4'((i + 1) % BUTTON_COUNT), 32'(i), 32'd0,
                                32'd0));
    send_command(command_item(CMD_CLEAR, 4'd0, 32'd0, 32'd0, 32'd0));
    wait_for_results();

    for (int stage = 0; stage < RANDOM_STAGES; stage++) begin
      gaps_enabled = (stage != 2);
      repeat (STAGE_ITEMS) send_command(random_command());
      wait_for_results();
    end

    repeat (6) @(posedge clk);
    sb.failures += sb.expected_reports.size();
    if (sb.failures == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end
endmodule
